@@ hw/rtl/msrl_pkg.sv @@
// ----------------------------------------------------------------------------
// msrl_pkg
// Shared constants, codes and controller/datapath interface types for the
// multichannel slew rate limiter.
// ----------------------------------------------------------------------------
package msrl_pkg;

    // Port count and derived index width
    localparam int NUM_PORTS = 10;
    localparam int IDX_W     = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

    // Fixed field widths
    localparam int CMD_W  = 2;
    localparam int PORT_W = 4;
    localparam int DATA_W = 8;
    localparam int STEP_W = 8;

    // Step size after reset
    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(15);

    // Command codes
    localparam logic [CMD_W-1:0] CMD_SET_EN    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SET_SPEED = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK      = 2'd2;

    // Controller -> datapath commands
    typedef struct packed {
        logic wr_enable;   // write enable flag of the requested port
        logic wr_target;   // store target speed of the requested port
        logic wr_drive;    // write drive directly and hold the request for output
        logic clr_idx;     // start a tick sweep at port 0
        logic tick_step;   // slew the current sweep port and load its result
        logic emit;        // load the held direct-drive result
    } t_dp_cmd;

    // Datapath -> controller status
    typedef struct packed {
        logic port_ok;     // requested port is in range
        logic port_en;     // requested port is slew limited
        logic out_free;    // output register can take a result this cycle
        logic idx_last;    // sweep is at the final port
    } t_dp_sts;

endpackage

@@ hw/rtl/msrl_ctrl.sv @@
// ----------------------------------------------------------------------------
// msrl_ctrl
// Controller: accepts one request at a time, decodes it into datapath
// commands and sequences the per-port tick sweep.
// ----------------------------------------------------------------------------
module msrl_ctrl
    import msrl_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [CMD_W-1:0] i_cmd,
    input  t_dp_sts          i_sts,
    output logic             o_stall,
    output t_dp_cmd          o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EMIT,
        S_TICK
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    // Only idle takes a new request
    assign o_stall = (r_state != S_IDLE);
    assign accept  = i_valid && (r_state == S_IDLE);

    // Next state and command decode
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_cmd)
                        CMD_SET_EN: begin
                            o_cmd.wr_enable = i_sts.port_ok;
                        end
                        CMD_SET_SPEED: begin
                            if (i_sts.port_ok) begin
                                if (i_sts.port_en) begin
                                    o_cmd.wr_target = 1'b1;
                                end else begin
                                    o_cmd.wr_drive = 1'b1;
                                    n_state        = S_EMIT;
                                end
                            end
                        end
                        CMD_TICK: begin
                            o_cmd.clr_idx = 1'b1;
                            n_state       = S_TICK;
                        end
                        default: begin
                            // unused code: dropped
                        end
                    endcase
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_TICK: begin
                if (i_sts.out_free) begin
                    o_cmd.tick_step = 1'b1;
                    if (i_sts.idx_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ hw/rtl/msrl_dp.sv @@
// ----------------------------------------------------------------------------
// msrl_dp
// Datapath: per-port enable/target/drive tables, step size register,
// shared slew unit, sweep index and the output register.
// ----------------------------------------------------------------------------
module msrl_dp
    import msrl_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [STEP_W-1:0]        i_cfg_wdata,
    input  logic [PORT_W-1:0]        i_port,
    input  logic signed [DATA_W-1:0] i_speed,
    input  logic                     i_enable,
    input  logic                     i_stall,
    input  t_dp_cmd                  i_cmd,
    output t_dp_sts                  o_sts,
    output logic                     o_valid,
    output logic [PORT_W-1:0]        o_out_port,
    output logic signed [DATA_W-1:0] o_drive,
    output logic                     o_last
);

    logic                     r_enabled [NUM_PORTS];
    logic signed [DATA_W-1:0] r_target  [NUM_PORTS];
    logic signed [DATA_W-1:0] r_drv     [NUM_PORTS];
    logic [STEP_W-1:0]        r_step;
    logic [IDX_W-1:0]         r_idx;
    logic [PORT_W-1:0]        r_port;
    logic signed [DATA_W-1:0] r_speed;

    logic                     r_ov;
    logic [PORT_W-1:0]        r_op;
    logic signed [DATA_W-1:0] r_od;
    logic                     r_ol;

    logic [IDX_W-1:0]         in_idx;
    logic signed [DATA_W:0]   diff;
    logic [DATA_W:0]          mag;
    logic signed [DATA_W+1:0] step_s;
    logic signed [DATA_W+1:0] moved;
    logic signed [DATA_W-1:0] slewed;
    logic signed [DATA_W-1:0] tick_val;

    // Request decode status
    assign in_idx         = IDX_W'(i_port);
    assign o_sts.port_ok  = (int'(i_port) < NUM_PORTS);
    assign o_sts.port_en  = r_enabled[in_idx];
    assign o_sts.out_free = !r_ov || !i_stall;
    assign o_sts.idx_last = (r_idx == IDX_W'(NUM_PORTS - 1));

    // Slew unit for the sweep port
    always_comb begin
        diff   = (DATA_W+1)'(r_target[r_idx]) - (DATA_W+1)'(r_drv[r_idx]);
        mag    = diff[DATA_W] ? (DATA_W+1)'(-diff) : $unsigned(diff);
        step_s = $signed({2'b00, r_step});
        if ({1'b0, mag} > $unsigned(step_s)) begin
            if (diff[DATA_W]) begin
                moved = (DATA_W+2)'(r_drv[r_idx]) - step_s;
            end else begin
                moved = (DATA_W+2)'(r_drv[r_idx]) + step_s;
            end
            slewed = moved[DATA_W-1:0];
        end else begin
            moved  = (DATA_W+2)'(r_target[r_idx]);
            slewed = r_target[r_idx];
        end
        tick_val = r_enabled[r_idx] ? slewed : r_drv[r_idx];
    end

    // Tables and step size
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_RESET;
            for (int i = 0; i < NUM_PORTS; i++) begin
                r_enabled[i] <= 1'b1;
                r_target[i]  <= '0;
                r_drv[i]     <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_step <= i_cfg_wdata;
            end
            if (i_cmd.wr_enable) begin
                r_enabled[in_idx] <= i_enable;
            end
            if (i_cmd.wr_target) begin
                r_target[in_idx] <= i_speed;
            end
            if (i_cmd.wr_drive) begin
                r_drv[in_idx] <= i_speed;
            end
            if (i_cmd.tick_step) begin
                r_drv[r_idx] <= tick_val;
            end
        end
    end

    // Sweep index and held direct-drive request
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_idx) begin
            r_idx <= '0;
        end else if (i_cmd.tick_step) begin
            r_idx <= r_idx + IDX_W'(1);
        end
        if (i_cmd.wr_drive) begin
            r_port  <= i_port;
            r_speed <= i_speed;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.tick_step || i_cmd.emit) begin
            r_ov <= 1'b1;
        end else if (!i_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tick_step) begin
            r_op <= PORT_W'(r_idx);
            r_od <= tick_val;
            r_ol <= o_sts.idx_last;
        end else if (i_cmd.emit) begin
            r_op <= r_port;
            r_od <= r_speed;
            r_ol <= 1'b1;
        end
    end

    assign o_valid    = r_ov;
    assign o_out_port = r_op;
    assign o_drive    = r_od;
    assign o_last     = r_ol;

endmodule

@@ hw/rtl/multichannel_slew_rate_limiter_unit.sv @@
// ----------------------------------------------------------------------------
// multichannel_slew_rate_limiter_unit
// Per-port enable/target/drive store with a slew limited tick sweep.
// ----------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  in       request    i_valid / o_stall     i_cmd, i_port, i_speed, i_enable
//  out      result     o_valid / i_stall     o_out_port, o_drive, o_last
//  cfg      write      i_cfg_we              i_cfg_wdata (step size)
//
//  Set enable, set speed on an enabled port, unused codes: complete on acceptance in idle.
//  Set speed on a disabled port: one result, loaded from the emit state.
//  Tick: one port per cycle through the shared slew unit while the output can take a result.
//  Output stalls add cycles only when the output register is still full.
//  Reset is synchronous; tables restore at once, no clearing pass.
// ----------------------------------------------------------------------------
module multichannel_slew_rate_limiter_unit
    import msrl_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [STEP_W-1:0]        i_cfg_wdata,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [CMD_W-1:0]         i_cmd,
    input  logic [PORT_W-1:0]        i_port,
    input  logic signed [DATA_W-1:0] i_speed,
    input  logic                     i_enable,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [PORT_W-1:0]        o_out_port,
    output logic signed [DATA_W-1:0] o_drive,
    output logic                     o_last
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // Sequencer
    msrl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_cmd   (i_cmd),
        .i_sts   (dp_sts),
        .o_stall (o_stall),
        .o_cmd   (dp_cmd)
    );

    // Tables, slew unit and output register
    msrl_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_port      (i_port),
        .i_speed     (i_speed),
        .i_enable    (i_enable),
        .i_stall     (i_stall),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .o_valid     (o_valid),
        .o_out_port  (o_out_port),
        .o_drive     (o_drive),
        .o_last      (o_last)
    );

    // An accepted tick keeps the request side busy for the sweep
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_cmd == CMD_TICK) |=> o_stall)
        else $error("tick accepted but sequencer not busy");

    // A result for the final port always carries the last tag
    a_last_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> (o_out_port != PORT_W'(NUM_PORTS - 1)))
        else $error("non-last result on final port");

    // The output register is loaded only while the controller is busy
    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (dp_cmd.tick_step || dp_cmd.emit) |-> o_stall)
        else $error("result loaded while idle");

    // Sweep and direct-drive loads never coincide, nor do drive and target writes
    a_one_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(dp_cmd.tick_step && dp_cmd.emit) && !(dp_cmd.wr_drive && dp_cmd.wr_target))
        else $error("conflicting datapath commands");

endmodule
